>>> rtl/rational_arithmetic_unit_defines.svh
// assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define RAU_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define RAU_ASSERT(label, clk, rst_n, prop)
`define RAU_ASSERT_NR(label, clk, prop)
`endif
`endif

>>> rtl/rau_pkg.sv
package rau_pkg;
    localparam int OPERAND_WIDTH = 32;
    localparam int MAG_W = 64;

    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;
    localparam logic [2:0] MODE_NEG = 3'd4;
    localparam logic [2:0] MODE_INC = 3'd5;
    localparam logic [2:0] MODE_DEC = 3'd6;
    localparam logic [2:0] MODE_RED = 3'd7;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_ZERO_DEN = 2'd1;
    localparam logic [1:0] ERR_DIV_ZERO = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    typedef struct packed {
        logic load;
        logic prep;
        logic mul;
        logic comb;
        logic gcd_step;
        logic div_start;
        logic div_step;
        logic fin;
    } rau_cmd_t;

    typedef struct packed {
        logic early_err;
        logic gcd_done;
        logic div_done;
    } rau_sts_t;
endpackage

>>> rtl/rau_datapath.sv
module rau_datapath (
    input  logic                       aclk,
    input  rau_pkg::rau_cmd_t          cmd,
    output rau_pkg::rau_sts_t          sts,
    input  logic [2:0]                 in_mode,
    input  logic [31:0]                in_an,
    input  logic [31:0]                in_ad,
    input  logic [31:0]                in_bn,
    input  logic [31:0]                in_bd,
    output logic [31:0]                res_num,
    output logic [30:0]                res_den,
    output logic [1:0]                 res_err
);
    localparam int W = rau_pkg::OPERAND_WIDTH;
    localparam int M = rau_pkg::MAG_W;

    logic [2:0]   mode_reg;
    logic [W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic         ann_reg, bnn_reg;
    logic [W:0]   anm, adm, bnm, bdm;
    logic [W:0]   anm_reg, adm_reg, bnm_reg, bdm_reg;
    logic [M-1:0] p1_reg, p2_reg, p3_reg;
    logic [M-1:0] num_reg, den_reg;
    logic         neg_reg;
    logic [M-1:0] x_reg, y_reg;
    logic [6:0]   sh_reg;
    logic [M-1:0] g_reg;
    logic [M-1:0] q_reg, r_reg;
    logic [6:0]   cnt_reg;
    logic         divsel_reg;
    logic [M-1:0] nq_reg;
    logic [1:0]   err_reg;
    logic [31:0]  rn_reg;
    logic [30:0]  rd_reg;

    function automatic logic [W:0] mag_of(input logic [W-1:0] v);
        logic [W:0] r;
        r = v[W-1] ? ({1'b0, ~v} + {{W{1'b0}}, 1'b1}) : {1'b0, v};
        return r;
    endfunction

    assign anm = mag_of(an_reg);
    assign adm = mag_of(ad_reg);
    assign bnm = mag_of(bn_reg);
    assign bdm = mag_of(bd_reg);

    logic two;
    assign two = (mode_reg == rau_pkg::MODE_ADD) || (mode_reg == rau_pkg::MODE_SUB)
              || (mode_reg == rau_pkg::MODE_MUL) || (mode_reg == rau_pkg::MODE_DIV);

    always_comb begin
        sts.early_err = (adm == '0) || (two && bdm == '0)
                     || (mode_reg == rau_pkg::MODE_DIV && bnm == '0);
        sts.gcd_done  = (x_reg == '0);
        sts.div_done  = (cnt_reg == '0);
    end

    logic [M-1:0] t1, t2, sum_mag;
    logic         t1n, t2n, sum_neg;

    always_comb begin
        t1 = p1_reg; t2 = p2_reg;
        t1n = ann_reg; t2n = bnn_reg;
        case (mode_reg)
            rau_pkg::MODE_SUB: t2n = ~bnn_reg;
            rau_pkg::MODE_INC: begin
                t1 = {{(M-W-1){1'b0}}, anm_reg}; t2 = {{(M-W-1){1'b0}}, adm_reg};
                t2n = 1'b0;
            end
            rau_pkg::MODE_DEC: begin
                t1 = {{(M-W-1){1'b0}}, anm_reg}; t2 = {{(M-W-1){1'b0}}, adm_reg};
                t2n = 1'b1;
            end
            default: ;
        endcase
        if (t1 == '0) t1n = 1'b0;
        if (t2 == '0) t2n = 1'b0;
        if (t1n == t2n) begin
            sum_mag = t1 + t2; sum_neg = t1n;
        end else if (t1 >= t2) begin
            sum_mag = t1 - t2; sum_neg = t1n;
        end else begin
            sum_mag = t2 - t1; sum_neg = t2n;
        end
    end

    logic [M-1:0] rw;
    logic [M:0]   rs;
    always_comb begin
        rw = {r_reg[M-2:0], q_reg[M-1]};
        rs = {r_reg, q_reg[M-1]} - {1'b0, g_reg};
    end

    logic [M-1:0] num_sel, den_sel, gdiff;
    logic         neg_sel;
    always_comb begin
        case (mode_reg)
            rau_pkg::MODE_ADD, rau_pkg::MODE_SUB, rau_pkg::MODE_INC,
            rau_pkg::MODE_DEC: begin
                num_sel = sum_mag; neg_sel = sum_neg;
            end
            rau_pkg::MODE_MUL, rau_pkg::MODE_DIV: begin
                num_sel = p1_reg; neg_sel = ann_reg ^ bnn_reg;
            end
            rau_pkg::MODE_NEG: begin
                num_sel = M'(anm_reg); neg_sel = ~ann_reg;
            end
            default: begin
                num_sel = M'(anm_reg); neg_sel = ann_reg;
            end
        endcase
        case (mode_reg)
            rau_pkg::MODE_ADD, rau_pkg::MODE_SUB, rau_pkg::MODE_MUL,
            rau_pkg::MODE_DIV: den_sel = p3_reg;
            default: den_sel = M'(adm_reg);
        endcase
        gdiff = (x_reg >= y_reg) ? (x_reg - y_reg) : (y_reg - x_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= in_mode;
            an_reg <= in_an[W-1:0]; ad_reg <= in_ad[W-1:0];
            bn_reg <= in_bn[W-1:0]; bd_reg <= in_bd[W-1:0];
        end
        if (cmd.prep) begin
            anm_reg <= anm; adm_reg <= adm; bnm_reg <= bnm; bdm_reg <= bdm;
            ann_reg <= (an_reg[W-1] ^ ad_reg[W-1]) && (anm != '0);
            bnn_reg <= (bn_reg[W-1] ^ bd_reg[W-1]) && (bnm != '0);
        end
        if (cmd.mul) begin
            p1_reg <= M'(anm_reg) * M'(mode_reg == rau_pkg::MODE_MUL ? bnm_reg : bdm_reg);
            p2_reg <= M'(bnm_reg) * M'(adm_reg);
            p3_reg <= M'(adm_reg) * M'(mode_reg == rau_pkg::MODE_DIV ? bnm_reg : bdm_reg);
        end
        if (cmd.comb) begin
            num_reg <= num_sel; neg_reg <= neg_sel; den_reg <= den_sel;
            x_reg <= num_sel; y_reg <= den_sel; sh_reg <= '0;
            divsel_reg <= 1'b0;
        end
        // binary gcd, y stays nonzero, gcd is y times two to the sh when x reaches zero
        if (cmd.gcd_step && x_reg != '0) begin
            if (!x_reg[0] && !y_reg[0]) begin
                x_reg <= x_reg >> 1; y_reg <= y_reg >> 1; sh_reg <= sh_reg + 7'd1;
            end else if (!x_reg[0]) begin
                x_reg <= x_reg >> 1;
            end else if (!y_reg[0]) begin
                y_reg <= y_reg >> 1;
            end else if (x_reg >= y_reg) begin
                x_reg <= gdiff >> 1;
            end else begin
                y_reg <= gdiff >> 1;
            end
        end
        if (cmd.div_start) begin
            g_reg <= y_reg << sh_reg;
            q_reg <= divsel_reg ? den_reg : num_reg;
            r_reg <= '0;
            cnt_reg <= 7'(M);
        end
        if (cmd.div_step) begin
            if (!rs[M]) begin
                r_reg <= rs[M-1:0];
                q_reg <= {q_reg[M-2:0], 1'b1};
            end else begin
                r_reg <= rw;
                q_reg <= {q_reg[M-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - 7'd1;
        end
        if (cmd.div_step && cnt_reg == 7'd1) begin
            if (!divsel_reg) nq_reg <= rs[M] ? {q_reg[M-2:0], 1'b0}
                                             : {q_reg[M-2:0], 1'b1};
            divsel_reg <= ~divsel_reg;
        end
        if (cmd.fin) begin
            if (sts.early_err) begin
                rn_reg <= '0; rd_reg <= 31'd1;
                err_reg <= (adm == '0 || (two && bdm == '0)) ? rau_pkg::ERR_ZERO_DEN
                                                            : rau_pkg::ERR_DIV_ZERO;
            end else if (nq_reg > M'((64'd1 << (W-1)) - 64'd1)
                      || q_reg > M'((64'd1 << (W-1)) - 64'd1) || q_reg == '0) begin
                rn_reg <= '0; rd_reg <= 31'd1; err_reg <= rau_pkg::ERR_OVERFLOW;
            end else begin
                rn_reg <= neg_reg && nq_reg != '0 ? 32'(-nq_reg) : 32'(nq_reg);
                rd_reg <= q_reg[30:0];
                err_reg <= rau_pkg::ERR_OK;
            end
        end
    end

    assign res_num = rn_reg;
    assign res_den = rd_reg;
    assign res_err = err_reg;
endmodule

>>> rtl/rau_ctrl.sv
`include "rational_arithmetic_unit_defines.svh"
module rau_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output rau_pkg::rau_cmd_t cmd,
    input  rau_pkg::rau_sts_t sts
);
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_PREP = 9'b000000010,
        S_MUL  = 9'b000000100,
        S_COMB = 9'b000001000,
        S_GCD  = 9'b000010000,
        S_DST  = 9'b000100000,
        S_DIV  = 9'b001000000,
        S_FIN  = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   pass_reg, pass_next;

    always_comb begin
        state_next = state_reg;
        pass_next = pass_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE: begin
                cmd.load = in_fire;
                if (in_fire) state_next = S_PREP;
            end
            S_PREP: begin
                cmd.prep = 1'b1;
                state_next = sts.early_err ? S_FIN : S_MUL;
            end
            S_MUL: begin
                cmd.mul = 1'b1; state_next = S_COMB;
            end
            S_COMB: begin
                cmd.comb = 1'b1; state_next = S_GCD; pass_next = 1'b0;
            end
            S_GCD: begin
                cmd.gcd_step = 1'b1;
                if (sts.gcd_done && pass_reg) begin
                    cmd.gcd_step = 1'b0; state_next = S_DST;
                end
                pass_next = 1'b1;
            end
            S_DST: begin
                cmd.div_start = 1'b1; state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) begin
                    cmd.div_step = 1'b0;
                    state_next = pass_reg ? S_DST : S_FIN;
                    pass_next = 1'b0;
                end
            end
            S_FIN: begin
                cmd.fin = 1'b1; state_next = S_OUT;
            end
            S_OUT: begin
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pass_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            pass_reg <= pass_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    `RAU_ASSERT(a_onehot, aclk, aresetn, $onehot(state_reg))
    `RAU_ASSERT(a_fire_prep, aclk, aresetn, in_fire |=> state_reg == S_PREP)
    `RAU_ASSERT(a_fin_out, aclk, aresetn, cmd.fin |=> out_valid)
    `RAU_ASSERT_NR(a_rst, aclk, !aresetn |=> state_reg == S_IDLE)
endmodule

>>> rtl/rational_arithmetic_unit.sv
// rational arithmetic unit: one result beat per input beat
// s_axis: tdata packs mode, a_numerator, a_denominator, b_numerator, b_denominator
// m_axis: tdata packs result_numerator, result_denominator, error_code
// an input beat is taken only while the unit is idle; the next beat is taken
// once the result beat has been taken by the receiver
// steps: load, sign decode, three parallel 33x33 multiplies, combine, then a
// binary gcd on 64-bit values (one halving or subtract per cycle), then two
// 64-step restoring divisions by the gcd, one bit a cycle
// an operand error skips the arithmetic and goes from sign decode straight
// to the final result register
// while m_axis_tready is low the result holds and no new beat is taken
// reset (aresetn low, synchronous) returns the controller to idle and drops
// m_axis_tvalid
module rational_arithmetic_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // mode[2:0], a_numerator[34:3], a_denominator[66:35], b_numerator[98:67],
    // b_denominator[130:99], zero fill
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_numerator[31:0], result_denominator[62:32], error_code[64:63], zero fill
    output logic [71:0]  m_axis_tdata
);
    rau_pkg::rau_cmd_t cmd;
    rau_pkg::rau_sts_t sts;
    logic [31:0] rn;
    logic [30:0] rd;
    logic [1:0]  re;

    rau_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (s_axis_tvalid && s_axis_tready),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    rau_datapath u_dp (
        .aclk    (aclk),
        .cmd     (cmd),
        .sts     (sts),
        .in_mode (s_axis_tdata[2:0]),
        .in_an   (s_axis_tdata[34:3]),
        .in_ad   (s_axis_tdata[66:35]),
        .in_bn   (s_axis_tdata[98:67]),
        .in_bd   (s_axis_tdata[130:99]),
        .res_num (rn),
        .res_den (rd),
        .res_err (re)
    );

    assign m_axis_tdata = {7'd0, re, rd, rn};
endmodule

>>> test/rational_arithmetic_unit_tb.sv
module rational_arithmetic_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] MODE_ADD = rau_pkg::MODE_ADD;
    localparam logic [2:0] MODE_SUB = rau_pkg::MODE_SUB;
    localparam logic [2:0] MODE_MUL = rau_pkg::MODE_MUL;
    localparam logic [2:0] MODE_DIV = rau_pkg::MODE_DIV;
    localparam logic [2:0] MODE_NEG = rau_pkg::MODE_NEG;
    localparam logic [2:0] MODE_INC = rau_pkg::MODE_INC;
    localparam logic [2:0] MODE_DEC = rau_pkg::MODE_DEC;
    localparam logic [2:0] MODE_RED = rau_pkg::MODE_RED;
    localparam logic [1:0] ERR_OK       = rau_pkg::ERR_OK;
    localparam logic [1:0] ERR_ZERO_DEN = rau_pkg::ERR_ZERO_DEN;
    localparam logic [1:0] ERR_DIV_ZERO = rau_pkg::ERR_DIV_ZERO;
    localparam logic [1:0] ERR_OVERFLOW = rau_pkg::ERR_OVERFLOW;

    localparam int RANDOM_BEATS = 1000;
    localparam int NUM_ROWS = 20;
    localparam logic [31:0] MOST_NEG = 32'h8000_0000;
    localparam logic [31:0] MOST_POS = 32'h7fff_ffff;

    typedef struct packed {
        logic signed [31:0] num;
        logic        [30:0] den;
        logic        [1:0]  err;
    } frac_result_t;

    typedef struct packed {
        logic [2:0]   mode;
        logic [31:0]  a_num;
        logic [31:0]  a_den;
        logic [31:0]  b_num;
        logic [31:0]  b_den;
        logic         typed;
        frac_result_t want;
    } frac_row_t;

    // rows with typed = 1 carry their expected result; the others go through the predictor
    localparam frac_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{MODE_ADD, 32'd1, 32'd2, 32'd1, 32'd3, 1'b1, '{32'sd5, 31'd6, ERR_OK}},
        '{MODE_SUB, 32'd1, 32'd2, 32'd1, 32'd2, 1'b1, '{32'sd0, 31'd1, ERR_OK}},
        '{MODE_MUL, MOST_POS, 32'd1, MOST_POS, 32'd1, 1'b1, '{32'sd0, 31'd1, ERR_OVERFLOW}},
        '{MODE_DIV, 32'd1, 32'd2, 32'd0, 32'd5, 1'b1, '{32'sd0, 31'd1, ERR_DIV_ZERO}},
        '{MODE_DIV, 32'd1, 32'd0, 32'd0, 32'd1, 1'b1, '{32'sd0, 31'd1, ERR_ZERO_DEN}},
        '{MODE_ADD, 32'd3, 32'd4, 32'd1, 32'd0, 1'b1, '{32'sd0, 31'd1, ERR_ZERO_DEN}},
        '{MODE_NEG, 32'd3, 32'd4, 32'd9, 32'd0, 1'b1, '{-32'sd3, 31'd4, ERR_OK}},
        '{MODE_NEG, MOST_NEG, 32'd1, 32'd0, 32'd0, 1'b1, '{32'sd0, 31'd1, ERR_OVERFLOW}},
        '{MODE_RED, MOST_NEG, 32'd2, 32'd0, 32'd0, 1'b0, '0},
        '{MODE_RED, 32'd6, -32'sd4, 32'd0, 32'd0, 1'b1, '{-32'sd3, 31'd2, ERR_OK}},
        '{MODE_INC, MOST_POS, 32'd1, 32'd0, 32'd0, 1'b1, '{32'sd0, 31'd1, ERR_OVERFLOW}},
        '{MODE_DEC, MOST_NEG, 32'd1, 32'd0, 32'd0, 1'b1, '{32'sd0, 31'd1, ERR_OVERFLOW}},
        '{MODE_INC, -32'sd1, 32'd1, 32'd0, 32'd0, 1'b1, '{32'sd0, 31'd1, ERR_OK}},
        '{MODE_MUL, MOST_NEG, MOST_POS, MOST_POS, MOST_NEG, 1'b1, '{32'sd1, 31'd1, ERR_OK}},
        '{MODE_DIV, -32'sd7, 32'd3, 32'd7, -32'sd3, 1'b1, '{32'sd1, 31'd1, ERR_OK}},
        '{MODE_ADD, MOST_POS, MOST_POS, MOST_NEG, MOST_NEG, 1'b1, '{32'sd2, 31'd1, ERR_OK}},
        '{MODE_SUB, 32'd1, MOST_POS, 32'd1, 32'h7fff_fffe, 1'b0, '0},
        '{MODE_RED, 32'd0, -32'sd5, 32'd0, 32'd0, 1'b1, '{32'sd0, 31'd1, ERR_OK}},
        '{MODE_DEC, 32'd5, 32'd3, 32'd0, 32'd0, 1'b1, '{32'sd2, 31'd3, ERR_OK}},
        '{MODE_MUL, 32'hffff_ffff, 32'hffff_fffe, 32'h5555_5555, 32'haaaa_aaab, 1'b0, '0}
    };

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;

    frac_result_t pending_results[$];
    int           send_idle_pct;
    int           recv_stall_pct;
    int           mismatches;
    int           unexpected;
    int           beats_sent;
    int           beats_checked;
    int           error_beats;

    rational_arithmetic_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // {sign, 64-bit magnitude} of a 32-bit two's complement operand
    function automatic logic [64:0] split_sign(logic [31:0] v);
        logic [31:0] m;
        m = v[31] ? (~v + 32'd1) : v;
        return {v[31], 32'd0, m};
    endfunction

    function automatic logic [64:0] signed_sum(logic xn, logic [63:0] xm,
                                               logic yn, logic [63:0] ym);
        logic        rn;
        logic [63:0] rm;
        if (xn == yn) begin
            rm = xm + ym;
            rn = xn;
        end else if (xm >= ym) begin
            rm = xm - ym;
            rn = xn;
        end else begin
            rm = ym - xm;
            rn = yn;
        end
        if (rm == 0) rn = 1'b0;
        return {rn, rm};
    endfunction

    function automatic frac_result_t reduce_fraction(logic [2:0] mode, logic [31:0] a_num,
                                                     logic [31:0] a_den, logic [31:0] b_num,
                                                     logic [31:0] b_den);
        logic        ann, adn, bnn, bdn, t1n, t2n, nn;
        logic [63:0] anm, adm, bnm, bdm, t1m, t2m, nm, dm, gx, gy, rem, lim;
        logic [31:0] nbits;
        frac_result_t r;
        {ann, anm} = split_sign(a_num);
        {adn, adm} = split_sign(a_den);
        {bnn, bnm} = split_sign(b_num);
        {bdn, bdm} = split_sign(b_den);
        r = '{32'sd0, 31'd1, ERR_OK};
        if (adm == 0 || (mode <= MODE_DIV && bdm == 0)) begin
            r.err = ERR_ZERO_DEN;
            return r;
        end
        if (mode == MODE_DIV && bnm == 0) begin
            r.err = ERR_DIV_ZERO;
            return r;
        end
        if (adn) ann = !ann;
        if (bdn) bnn = !bnn;
        if (anm == 0) ann = 1'b0;
        if (bnm == 0) bnn = 1'b0;
        case (mode)
            MODE_ADD, MODE_SUB: begin
                t1m = anm * bdm;
                t1n = ann;
                t2m = bnm * adm;
                t2n = (mode == MODE_SUB) ? !bnn : bnn;
                if (t2m == 0) t2n = 1'b0;
                {nn, nm} = signed_sum(t1n, t1m, t2n, t2m);
                dm = adm * bdm;
            end
            MODE_MUL: begin
                nm = anm * bnm;
                nn = ann != bnn;
                dm = adm * bdm;
            end
            MODE_DIV: begin
                nm = anm * bdm;
                nn = ann != bnn;
                dm = adm * bnm;
            end
            MODE_NEG: begin
                nm = anm;
                nn = !ann;
                dm = adm;
            end
            MODE_INC, MODE_DEC: begin
                {nn, nm} = signed_sum(ann, anm, mode == MODE_DEC, adm);
                dm = adm;
            end
            default: begin
                nm = anm;
                nn = ann;
                dm = adm;
            end
        endcase
        if (nm == 0) nn = 1'b0;
        gx = nm;
        gy = dm;
        while (gy != 0) begin
            rem = gx % gy;
            gx = gy;
            gy = rem;
        end
        if (gx == 0) gx = 1;
        nm = nm / gx;
        dm = dm / gx;
        lim = 64'h7fff_ffff;
        if (nm > lim || dm > lim || dm == 0) begin
            r.err = ERR_OVERFLOW;
            return r;
        end
        nbits = nm[31:0];
        r.num = nn ? -nbits : nbits;
        r.den = dm[30:0];
        return r;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 11))
            0:       return 32'd0;
            1:       return MOST_NEG;
            2:       return MOST_POS;
            3:       return 32'hffff_ffff;
            4, 5:    return 32'($urandom_range(0, 40)) - 32'd20;
            6, 7:    return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(logic [2:0] mode, logic [31:0] a_num, logic [31:0] a_den,
                             logic [31:0] b_num, logic [31:0] b_den, frac_result_t want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, b_den, b_num, a_den, a_num, mode};
        do @(negedge aclk); while (!s_axis_tready);
        @(posedge aclk);
        pending_results.push_back(want);
        beats_sent++;
    endtask

    // result side: check each beat at the falling edge before the rising edge that takes it
    always @(negedge aclk) begin
        frac_result_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.num = m_axis_tdata[31:0];
            got.den = m_axis_tdata[62:32];
            got.err = m_axis_tdata[64:63];
            beats_checked++;
            if (got.err != ERR_OK) error_beats++;
            if (pending_results.size() == 0) begin
                unexpected++;
                $display("unexpected result beat num=%0d den=%0d err=%0d",
                         got.num, got.den, got.err);
            end else begin
                want = pending_results.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d err %0d, got %0d/%0d err %0d",
                                 want.num, want.den, want.err, got.num, got.den, got.err);
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        #100ms;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("FAIL");
        $finish;
    end

    initial begin
        frac_row_t    row;
        frac_result_t want;
        logic [2:0]   mode;
        logic [31:0]  an, ad, bn, bd;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatches     = 0;
        unexpected     = 0;
        beats_sent     = 0;
        beats_checked  = 0;
        error_beats    = 0;
        aresetn        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++) begin
            row  = DIRECTED_ROWS[i];
            want = row.typed ? row.want
                             : reduce_fraction(row.mode, row.a_num, row.a_den, row.b_num,
                                               row.b_den);
            send_beat(row.mode, row.a_num, row.a_den, row.b_num, row.b_den, want);
        end

        for (int i = 0; i < RANDOM_BEATS; i++) begin
            case (i / (RANDOM_BEATS / 4))
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            mode = 3'($urandom);
            an   = pick_operand();
            ad   = pick_operand();
            bn   = pick_operand();
            bd   = pick_operand();
            send_beat(mode, an, ad, bn, bd, reduce_fraction(mode, an, ad, bn, bd));
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);

        $display("%0d fraction beats sent, %0d results checked (%0d with an error code)",
                 beats_sent, beats_checked, error_beats);
        $display("all eight modes under four idle/stall mixes; %0d mismatches, %0d unexpected",
                 mismatches, unexpected);
        if (mismatches == 0 && unexpected == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl
rtl/rau_pkg.sv
rtl/rau_datapath.sv
rtl/rau_ctrl.sv
rtl/rational_arithmetic_unit.sv
test/rational_arithmetic_unit_tb.sv
